// ===== rtl/core/scse_pkg.sv =====
package scse_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_FF     = 8'h0C;
    localparam logic [7:0] CHR_NL     = 8'h0A;
    localparam logic [7:0] CHR_HASH   = 8'h23;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_LOW_S  = 8'h73;
    localparam logic [7:0] CHR_LOW_N  = 8'h6E;

    localparam logic [2:0] WORD_LEN   = 3'd6;
    localparam logic [2:0] DEFINE_LEN = 3'd7;

    localparam logic [1:0] PHASE_NONE   = 2'd0;
    localparam logic [1:0] PHASE_DEFINE = 2'd1;
    localparam logic [1:0] PHASE_SOURCE = 2'd2;

    // One queued request: a fixed prefix followed by an optional escaped byte.
    typedef struct packed {
        logic       is_define;
        logic [2:0] pre_len;
        logic       has_byte;
        logic [7:0] data;
    } cmd_t;

    // Letters of "source", index 0 to 5.
    function automatic logic [7:0] src_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h73;
            3'd1: ch = 8'h6F;
            3'd2: ch = 8'h75;
            3'd3: ch = 8'h72;
            3'd4: ch = 8'h63;
            3'd5: ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of "#define", index 0 to 6.
    function automatic logic [7:0] def_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h23;
            3'd1: ch = 8'h64;
            3'd2: ch = 8'h65;
            3'd3: ch = 8'h66;
            3'd4: ch = 8'h69;
            3'd5: ch = 8'h6E;
            3'd6: ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/core/scse_fifo.sv =====
module scse_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scse_pkg::cmd_t push_cmd,
    input  logic           pop,
    output scse_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);
    import scse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/scse_front.sv =====
module scse_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           drop_source,
    input  logic           queue_full,
    output logic           push,
    output scse_pkg::cmd_t push_cmd
);
    import scse_pkg::*;

    logic       at_line_start_reg, at_line_start_next;
    logic       in_comment_reg, in_comment_next;
    logic       swallow_reg, swallow_next;
    logic [1:0] phase_reg, phase_next;
    logic [2:0] count_reg, count_next;

    logic       accept;
    logic       emit;
    logic       do_classify;
    logic [2:0] src_len;
    cmd_t       cmd;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && emit;
    assign push_cmd = cmd;
    assign src_len  = (count_reg > WORD_LEN) ? WORD_LEN : count_reg;

    always_comb begin
        at_line_start_next = at_line_start_reg;
        in_comment_next    = in_comment_reg;
        swallow_next       = swallow_reg;
        phase_next         = phase_reg;
        count_next         = count_reg;
        emit               = 1'b0;
        do_classify        = 1'b0;
        cmd                = '0;
        cmd.data           = s_tdata;

        if (s_tlast) begin
            if (phase_reg == PHASE_SOURCE) begin
                emit        = 1'b1;
                cmd.pre_len = src_len;
            end
            at_line_start_next = 1'b1;
            in_comment_next    = 1'b0;
            swallow_next       = 1'b0;
            phase_next         = PHASE_NONE;
            count_next         = '0;
        end else if (swallow_reg) begin
            swallow_next = 1'b0;
        end else if (phase_reg == PHASE_DEFINE) begin
            if (count_reg < WORD_LEN && s_tdata == def_char(count_reg + 3'd1)) begin
                count_next = count_reg + 3'd1;
                if (count_next == WORD_LEN) begin
                    emit               = 1'b1;
                    cmd.is_define      = 1'b1;
                    cmd.pre_len        = DEFINE_LEN;
                    at_line_start_next = 1'b0;
                    phase_next         = PHASE_NONE;
                    count_next         = '0;
                end
            end else begin
                phase_next      = PHASE_NONE;
                count_next      = '0;
                in_comment_next = 1'b1;
                do_classify     = 1'b1;
            end
        end else if (phase_reg == PHASE_SOURCE) begin
            if (count_reg < WORD_LEN && s_tdata == src_char(count_reg)) begin
                count_next = count_reg + 3'd1;
            end else if (count_reg >= WORD_LEN
                         && (s_tdata == CHR_SPACE || s_tdata == CHR_TAB)) begin
                in_comment_next = 1'b1;
                phase_next      = PHASE_NONE;
                count_next      = '0;
            end else begin
                // The prefix goes out and the breaking byte follows it unclassified.
                emit               = 1'b1;
                cmd.pre_len        = src_len;
                cmd.has_byte       = 1'b1;
                at_line_start_next = 1'b0;
                phase_next         = PHASE_NONE;
                count_next         = '0;
            end
        end else begin
            phase_next  = PHASE_NONE;
            do_classify = 1'b1;
        end

        if (do_classify) begin
            cmd.has_byte = 1'b1;
            case (s_tdata)
                CHR_SPACE, CHR_TAB, CHR_FF: begin
                    emit = !(at_line_start_next || in_comment_next);
                end
                CHR_HASH: begin
                    if (at_line_start_next) begin
                        phase_next = PHASE_DEFINE;
                        count_next = '0;
                    end else begin
                        emit = !in_comment_next;
                    end
                end
                CHR_NL: begin
                    at_line_start_next = 1'b1;
                    if (in_comment_next) begin
                        in_comment_next = 1'b0;
                    end else begin
                        emit = 1'b1;
                    end
                end
                CHR_BSLASH: begin
                    if (in_comment_next) begin
                        swallow_next = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                CHR_LOW_S: begin
                    if (!in_comment_next) begin
                        if (at_line_start_next && drop_source) begin
                            phase_next = PHASE_SOURCE;
                            count_next = 3'd1;
                        end else begin
                            at_line_start_next = 1'b0;
                            emit               = 1'b1;
                        end
                    end
                end
                default: begin
                    at_line_start_next = 1'b0;
                    emit               = !in_comment_next;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_line_start_reg <= 1'b1;
            in_comment_reg    <= 1'b0;
            swallow_reg       <= 1'b0;
            phase_reg         <= PHASE_NONE;
            count_reg         <= '0;
        end else if (accept) begin
            at_line_start_reg <= at_line_start_next;
            in_comment_reg    <= in_comment_next;
            swallow_reg       <= swallow_next;
            phase_reg         <= phase_next;
            count_reg         <= count_next;
        end
    end

endmodule

// ===== rtl/core/scse_back.sv =====
module scse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           escape_en,
    input  logic           queue_empty,
    input  scse_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import scse_pkg::*;

    cmd_t       cur_cmd_reg;
    logic       cur_valid_reg, cur_valid_next;
    logic [3:0] pos_reg, pos_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;

    logic       esc_pair;
    logic       esc_nl;
    logic [2:0] esc_len;
    logic [3:0] total;
    logic [1:0] esc_idx;
    logic       is_last;
    logic       advance;
    logic [7:0] ch;

    assign esc_pair = escape_en && (cur_cmd_reg.data == CHR_BSLASH
                                    || cur_cmd_reg.data == CHR_QUOTE);
    assign esc_nl   = escape_en && (cur_cmd_reg.data == CHR_NL);
    assign esc_len  = !cur_cmd_reg.has_byte ? 3'd0 :
                      esc_nl                ? 3'd4 :
                      esc_pair              ? 3'd2 : 3'd1;
    assign total    = {1'b0, cur_cmd_reg.pre_len} + {1'b0, esc_len};
    assign is_last  = (pos_reg == total - 4'd1);
    assign esc_idx  = 2'(pos_reg - {1'b0, cur_cmd_reg.pre_len});
    assign advance  = cur_valid_reg && (!out_valid_reg || m_tready);
    assign pop      = !queue_empty && (!cur_valid_reg || (advance && is_last));

    always_comb begin
        if (pos_reg < {1'b0, cur_cmd_reg.pre_len}) begin
            ch = cur_cmd_reg.is_define ? def_char(pos_reg[2:0]) : src_char(pos_reg[2:0]);
        end else if (esc_nl) begin
            case (esc_idx)
                2'd0: ch = CHR_BSLASH;
                2'd1: ch = CHR_LOW_N;
                2'd2: ch = CHR_BSLASH;
                default: ch = CHR_NL;
            endcase
        end else if (esc_pair && esc_idx == 2'd0) begin
            ch = CHR_BSLASH;
        end else begin
            ch = cur_cmd_reg.data;
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            pos_next       = pos_reg + 4'd1;
            if (is_last) begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop) begin
            cur_valid_next = 1'b1;
            pos_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_cmd_reg <= head_cmd;
        end
        if (advance) begin
            out_data_reg <= ch;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/script_comment_strip_escaper.sv =====
// Script comment stripper and C-string escaper.
// Input stream: one script byte per request on s_tdata; s_tlast marks end of
// stream, which flushes a pending "source" prefix and returns the parser to
// the start of a line (s_tdata is ignored on that request).
// Output stream: escaped bytes on m_tdata; m_tlast is high on the final byte
// produced by one input request. A request may produce no bytes at all.
// Registers (APB): 0x0 bit 0 drops "source" lines, 0x4 bit 0 enables escaping.
// Both read back and reset to 1; write them only while the block is idle.
// The front end accepts one request per cycle while the command queue has
// room, so s_tready stays high as long as output keeps up.
// The back end sends one byte per cycle while m_tready is high; a request
// expands to 0 to 10 bytes, which sets the sustained input rate. With nothing
// queued ahead of it, the first byte of a request passes the queue write, the
// expander load and the output register before it is on m_tdata.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and s_tready drops once QUEUE_DEPTH commands are waiting.
// Reset clears parser state and queue and sets both registers to 1.
module script_comment_strip_escaper #(
    parameter int QUEUE_DEPTH = scse_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scse_pkg::*;

    logic drop_source_reg;
    logic escape_en_reg;
    logic cfg_write;
    logic push, pop, queue_empty, queue_full;
    cmd_t push_cmd, head_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {31'b0, escape_en_reg} : {31'b0, drop_source_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_source_reg <= 1'b1;
            escape_en_reg   <= 1'b1;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                escape_en_reg <= pwdata[0];
            end else begin
                drop_source_reg <= pwdata[0];
            end
        end
    end

    scse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .drop_source (drop_source_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    scse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    scse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .escape_en   (escape_en_reg),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== rtl/core/scse_checker.sv =====
module scse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [31:0] prdata
);

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Reset empties the command queue, so input is accepted right away.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // Both registers are single bits; nothing else reads back.
    a_prdata_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        prdata[31:1] == 31'b0)
        else $error("read data has stray upper bits");

endmodule

bind script_comment_strip_escaper scse_checker u_scse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .prdata   (prdata)
);

// ===== test/tb.sv =====
module tb;
    import scse_pkg::*;

    localparam int MAX_BURST     = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 100;
    localparam int N_ROWS        = 24;

    localparam logic [2:0] REG_DROP_SOURCE = 3'd0;
    localparam logic [2:0] REG_ESCAPE      = 3'd4;

    localparam logic [47:0] SOURCE_TXT = "source";
    localparam logic [47:0] DEFINE_TXT = "define";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } in_t;

    // One directed request; seq holds up to four known output bytes, first byte lowest.
    typedef struct packed {
        logic [7:0]  data;
        logic        eos;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] seq;
    } row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    script_comment_strip_escaper u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted output bytes, oldest first.
    out_t       pending_bytes[$];
    logic [7:0] burst[$];
    in_t        script_q[$];
    int         bad_count   = 0;
    bit         no_gaps     = 1'b0;
    int         hold_left   = 0;

    // Mirror of the parser and its registers.
    bit         drop_on;
    bit         esc_on;
    bit         line_start;
    bit         in_cmt;
    bit         swallow;
    logic [1:0] phase;
    int         mcount;

    row_t dir_rows [N_ROWS] = '{
        '{8'h00,      1'b0, 1'b1, 3'd1, 32'h0000_0000},
        '{8'hFF,      1'b0, 1'b1, 3'd1, 32'h0000_00FF},
        '{CHR_QUOTE,  1'b0, 1'b1, 3'd2, 32'h0000_225C},
        '{CHR_BSLASH, 1'b0, 1'b1, 3'd2, 32'h0000_5C5C},
        '{CHR_NL,     1'b0, 1'b1, 3'd4, 32'h0A5C_6E5C},
        '{CHR_SPACE,  1'b0, 1'b1, 3'd0, 32'h0000_0000},
        '{CHR_HASH,   1'b0, 1'b1, 3'd0, 32'h0000_0000},
        '{"d",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"e",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"f",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"i",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"n",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"e",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_NL,     1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_HASH,   1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"x",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_BSLASH, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_NL,     1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_NL,     1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{CHR_LOW_S,  1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"o",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{"u",        1'b0, 1'b0, 3'd0, 32'h0000_0000},
        '{8'hFF,      1'b1, 1'b1, 3'd3, 32'h0075_6F73},
        '{8'h00,      1'b1, 1'b1, 3'd0, 32'h0000_0000}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("script_comment_strip_escaper test failed");
        $finish;
    end

    function automatic logic [7:0] letter(input logic [47:0] word, input int k);
        return word[47 - 8 * k -: 8];
    endfunction

    function automatic void put_raw(input logic [7:0] b);
        if (burst.size() < MAX_BURST)
            burst.push_back(b);
    endfunction

    function automatic void put_esc(input logic [7:0] b);
        if (esc_on) begin
            if (b == CHR_BSLASH || b == CHR_QUOTE) begin
                put_raw(CHR_BSLASH);
            end else if (b == CHR_NL) begin
                put_raw(CHR_BSLASH);
                put_raw(CHR_LOW_N);
                put_raw(CHR_BSLASH);
            end
        end
        put_raw(b);
    endfunction

    function automatic void flush_source_prefix();
        int lim;
        lim = (mcount > 6) ? 6 : mcount;
        for (int k = 0; k < lim; k++)
            put_esc(letter(SOURCE_TXT, k));
    endfunction

    function automatic void classify(input logic [7:0] b);
        case (b)
            CHR_SPACE, CHR_TAB, CHR_FF: begin
                if (!(line_start || in_cmt))
                    put_esc(b);
            end
            CHR_HASH: begin
                if (line_start) begin
                    phase  = PHASE_DEFINE;
                    mcount = 0;
                end else if (!in_cmt) begin
                    put_esc(b);
                end
            end
            CHR_NL: begin
                line_start = 1'b1;
                if (in_cmt)
                    in_cmt = 1'b0;
                else
                    put_esc(b);
            end
            CHR_BSLASH: begin
                if (in_cmt)
                    swallow = 1'b1;
                else
                    put_esc(b);
            end
            CHR_LOW_S: begin
                if (!in_cmt) begin
                    if (line_start && drop_on) begin
                        phase  = PHASE_SOURCE;
                        mcount = 1;
                    end else begin
                        line_start = 1'b0;
                        put_esc(b);
                    end
                end
            end
            default: begin
                line_start = 1'b0;
                if (!in_cmt)
                    put_esc(b);
            end
        endcase
    endfunction

    function automatic void clear_parser();
        line_start = 1'b1;
        in_cmt     = 1'b0;
        swallow    = 1'b0;
        phase      = PHASE_NONE;
        mcount     = 0;
    endfunction

    // Works out the bytes one request produces and advances the mirror state.
    function automatic void filter_byte(input logic [7:0] b, input logic eos);
        burst.delete();
        if (eos) begin
            if (phase == PHASE_SOURCE)
                flush_source_prefix();
            clear_parser();
        end else if (swallow) begin
            swallow = 1'b0;
        end else if (phase == PHASE_DEFINE) begin
            if (mcount < 6 && b == letter(DEFINE_TXT, mcount)) begin
                mcount++;
                if (mcount >= 6) begin
                    put_esc(CHR_HASH);
                    for (int k = 0; k < 6; k++)
                        put_esc(letter(DEFINE_TXT, k));
                    line_start = 1'b0;
                    phase      = PHASE_NONE;
                    mcount     = 0;
                end
            end else begin
                phase  = PHASE_NONE;
                mcount = 0;
                in_cmt = 1'b1;
                classify(b);
            end
        end else if (phase == PHASE_SOURCE) begin
            if (mcount < 6 && b == letter(SOURCE_TXT, mcount)) begin
                mcount++;
            end else if (mcount >= 6 && (b == CHR_SPACE || b == CHR_TAB)) begin
                in_cmt = 1'b1;
                phase  = PHASE_NONE;
                mcount = 0;
            end else begin
                flush_source_prefix();
                put_esc(b);
                line_start = 1'b0;
                phase      = PHASE_NONE;
                mcount     = 0;
            end
        end else begin
            phase = PHASE_NONE;
            classify(b);
        end
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic e);
        script_q.push_back('{b, e});
    endfunction

    function automatic void add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            add_byte(t[i], 1'b0);
    endfunction

    function automatic void add_word(input int len);
        for (int i = 0; i < len; i++)
            add_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    endfunction

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 2))
            0: return CHR_SPACE;
            1: return CHR_TAB;
            default: return CHR_FF;
        endcase
    endfunction

    // Mostly well-formed script lines with random content, plus noise and broken lines.
    function automatic void make_script(input int count);
        int pick;
        int len;
        while (script_q.size() < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                add_text("source");
                add_byte($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB, 1'b0);
                add_word($urandom_range(1, 5));
                add_byte(CHR_NL, 1'b0);
            end else if (pick < 25) begin
                add_text("#define X \"1\"");
                add_byte(CHR_NL, 1'b0);
            end else if (pick < 38) begin
                add_byte(CHR_HASH, 1'b0);
                add_byte(any_blank(), 1'b0);
                add_word($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    add_byte(CHR_BSLASH, 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
                add_byte(CHR_NL, 1'b0);
            end else if (pick < 43) begin
                add_text("##define");
                add_word($urandom_range(0, 2));
                add_byte(CHR_NL, 1'b0);
            end else if (pick < 55) begin
                // A source prefix broken by any byte, the full word included.
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    add_byte(letter(SOURCE_TXT, k), 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 60) begin
                len = $urandom_range(0, 6);
                for (int k = 0; k < len; k++)
                    add_byte(letter(SOURCE_TXT, k), 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end else if (pick < 66) begin
                add_byte(CHR_HASH, 1'b0);
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++)
                    add_byte(letter(DEFINE_TXT, k), 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 76) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    add_byte(any_blank(), 1'b0);
                add_word($urandom_range(1, 4));
                add_byte(any_blank(), 1'b0);
                add_byte(CHR_LOW_S, 1'b0);
                add_byte(CHR_NL, 1'b0);
            end else if (pick < 87) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 93) begin
                add_word($urandom_range(0, 2));
                add_byte($urandom_range(0, 1) ? CHR_QUOTE : CHR_BSLASH, 1'b0);
                add_byte(CHR_HASH, 1'b0);
                add_byte(CHR_NL, 1'b0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
        end
    endfunction

    // Offers one request, waits for it to be taken, then records what it must produce.
    task automatic send_item(input logic [7:0] d, input logic e, input bit typed,
                             input int n, input logic [31:0] seq);
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= e;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        filter_byte(d, e);
        if (typed) begin
            for (int i = 0; i < n; i++)
                pending_bytes.push_back('{seq[8 * i +: 8], i == n - 1});
        end else begin
            for (int i = 0; i < burst.size(); i++)
                pending_bytes.push_back('{burst[i], i == burst.size() - 1});
        end
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== {31'd0, v}) begin
            $error("register %0d readback: expected %0h, actual %0h", addr, v, prdata);
            bad_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (addr == REG_DROP_SOURCE)
            drop_on = v;
        else
            esc_on = v;
    endtask

    // Receiver: random back-pressure, a steady stretch, and one long hold-off.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("output byte %0h with nothing predicted", m_tdata);
                bad_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %0h, actual %0h", want.data, m_tdata);
                    bad_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    bad_count++;
                end
            end
        end
    end

    initial begin
        drop_on = 1'b1;
        esc_on  = 1'b1;
        clear_parser();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send_item(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed,
                      dir_rows[i].n, dir_rows[i].seq);
        s_tvalid <= 1'b0;
        settle();

        // Settings run from both off to both on; the phase index gives the two bits.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_DROP_SOURCE, p[0]);
            write_reg(REG_ESCAPE, p[1]);
            make_script(PHASE_ITEMS);
            for (int i = 0; i < script_q.size(); i++) begin
                no_gaps = (p == 2) && (i < 60);
                if (p == 1 && i == 10)
                    hold_left = HOLD_CYCLES;
                send_item(script_q[i].data, script_q[i].eos, 1'b0, 0, 32'd0);
            end
            no_gaps = 1'b0;
            script_q.delete();
            s_tvalid <= 1'b0;
            settle();
        end

        if (bad_count == 0)
            $display("script_comment_strip_escaper test passed");
        else
            $display("script_comment_strip_escaper test failed");
        $finish;
    end

endmodule
